[rtl/core/cvm_pkg.sv]
// ----------------------------------------------------------------------------
// cvm_pkg
// Shared constants for the cube-to-sphere vertex morph pipeline.
// ----------------------------------------------------------------------------
package cvm_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int MF_W      = 12;
	localparam int R_W       = 15;
	localparam int CFG_W     = 15;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int ROOT_STEPS = 32;
	localparam int QUOT_W    = 17;
	localparam int K_W       = 5;
	localparam int K_MAX     = 16;
	localparam int LANES     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MORPH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;

	localparam logic signed [MF_W-1:0] MORPH_RESET  = 12'sd0;
	localparam logic [R_W-1:0]         RADIUS_RESET = 15'd1920;

endpackage

[rtl/core/cvm_sqrt.sv]
// ----------------------------------------------------------------------------
// cvm_sqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module cvm_sqrt #(
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [cvm_pkg::RAD_W-1:0]   in_rad,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [cvm_pkg::ROOT_W-1:0]  out_root,
	output logic [PW-1:0]               out_pay
);
	import cvm_pkg::*;

	logic             vld_s [ROOT_STEPS];
	logic [RAD_W-1:0] rem_s [ROOT_STEPS];
	logic [RAD_W-1:0] res_s [ROOT_STEPS];
	logic [PW-1:0]    pay_s [ROOT_STEPS];

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
		logic             v_in;
		logic [RAD_W-1:0] rem_in;
		logic [RAD_W-1:0] res_in;
		logic [PW-1:0]    pay_in;
		logic [RAD_W-1:0] trial;

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = in_rad;
			assign res_in = '0;
			assign pay_in = in_pay;
		end else begin : g_next
			assign v_in   = vld_s[i-1];
			assign rem_in = rem_s[i-1];
			assign res_in = res_s[i-1];
			assign pay_in = pay_s[i-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[i] <= pay_in;
				if (rem_in >= trial) begin
					rem_s[i] <= rem_in - trial;
					res_s[i] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[i] <= rem_in;
					res_s[i] <= res_in >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_STEPS-1];
	assign out_root  = res_s[ROOT_STEPS-1][ROOT_W-1:0];
	assign out_pay   = pay_s[ROOT_STEPS-1];

endmodule

[rtl/core/cvm_div.sv]
// ----------------------------------------------------------------------------
// cvm_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with side payload.
// ----------------------------------------------------------------------------
module cvm_div #(
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [cvm_pkg::RAD_W-1:0]   in_num [cvm_pkg::LANES],
	input  logic [cvm_pkg::ROOT_W-1:0]  in_den,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [cvm_pkg::QUOT_W-1:0]  out_quot [cvm_pkg::LANES],
	output logic [PW-1:0]               out_pay
);
	import cvm_pkg::*;

	logic              vld_s [QUOT_W];
	logic [ROOT_W-1:0] den_s [QUOT_W];
	logic [RAD_W-1:0]  rem_s [QUOT_W][LANES];
	logic [QUOT_W-1:0] quo_s [QUOT_W][LANES];
	logic [PW-1:0]     pay_s [QUOT_W];

	for (genvar i = 0; i < QUOT_W; i++) begin : g_step
		localparam int SH = QUOT_W - 1 - i;
		logic              v_in;
		logic [ROOT_W-1:0] den_in;
		logic [PW-1:0]     pay_in;
		logic [RAD_W:0]    dsh;

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign den_in = in_den;
			assign pay_in = in_pay;
		end else begin : g_next
			assign v_in   = vld_s[i-1];
			assign den_in = den_s[i-1];
			assign pay_in = pay_s[i-1];
		end

		assign dsh = (RAD_W + 1)'(den_in) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_in;
				pay_s[i] <= pay_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [RAD_W-1:0]  rem_in;
			logic [QUOT_W-1:0] quo_in;

			if (i == 0) begin : g_first
				assign rem_in = in_num[l];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[i-1][l];
				assign quo_in = quo_s[i-1][l];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if ({1'b0, rem_in} >= dsh) begin
						rem_s[i][l] <= rem_in - dsh[RAD_W-1:0];
						quo_s[i][l] <= quo_in | (QUOT_W'(1) << SH);
					end else begin
						rem_s[i][l] <= rem_in;
						quo_s[i][l] <= quo_in;
					end
				end
			end
		end
	end

	assign out_valid = vld_s[QUOT_W-1];
	assign out_pay   = pay_s[QUOT_W-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quot[l] = quo_s[QUOT_W-1][l];
	end

endmodule

[rtl/core/cube_to_sphere_vertex_morph_unit.sv]
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex_morph_unit
// Projects a vertex onto a sphere of configured radius and blends toward it.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  vertex  | in_valid, in_stall, in_x/y/z             | in
//  result  | out_valid, out_stall, out_x/y/z, flags   | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One vertex per cycle while a stalled output beat is not holding the pipeline;
// the square root and divider pipelines each resolve one bit per stage.
// Reset clears all valid bits and loads the register defaults.
// A stalled output beat freezes the whole pipeline; in_stall follows it.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module cube_to_sphere_vertex_morph_unit #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_WIDTH-1:0]         in_x,
	input  logic signed [COORD_WIDTH-1:0]         in_y,
	input  logic signed [COORD_WIDTH-1:0]         in_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_WIDTH-1:0]         out_x,
	output logic signed [COORD_WIDTH-1:0]         out_y,
	output logic signed [COORD_WIDTH-1:0]         out_z,
	output logic                                  at_origin,
	output logic                                  clipped,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cvm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cvm_pkg::CFG_W-1:0]             cfg_data
);
	import cvm_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int SW  = 2 * W;
	localparam int BLW = $clog2(SW + 1);
	localparam int DW  = ((W > QUOT_W + 1) ? W : QUOT_W + 1) + 1;
	localparam int SP_W = LANES * W + 1 + K_W;
	localparam int DP_W = LANES * W + 1;

	logic signed [MF_W-1:0] morph_q;
	logic [R_W-1:0]         radius_q;
	logic                   en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			morph_q  <= MORPH_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MORPH:  morph_q  <= cfg_data[MF_W-1:0];
				CFG_RADIUS: radius_q <= cfg_data[R_W-1:0];
				default: ;
			endcase
		end
	end

	// s1: squares
	logic                 vld_s1;
	logic signed [W-1:0]  c_s1 [LANES];
	logic [SW-1:0]        sq_s1 [LANES];
	logic signed [W-1:0]  c_in [LANES];

	assign c_in[0] = in_x;
	assign c_in[1] = in_y;
	assign c_in[2] = in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_sq
		logic [W-1:0] m;
		assign m = c_in[l][W-1] ? W'(-c_in[l]) : W'(c_in[l]);
		always_ff @(posedge clk) begin
			if (en) begin
				c_s1[l]  <= c_in[l];
				sq_s1[l] <= SW'(m) * SW'(m);
			end
		end
	end

	// s2: sum
	logic                vld_s2;
	logic signed [W-1:0] c_s2 [LANES];
	logic [SW-1:0]       sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_s1;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// s3: normalizing shift
	logic [BLW-1:0] bitlen;
	logic [6:0]     kraw;
	logic [K_W-1:0] kval;

	always_comb begin
		bitlen = '0;
		for (int j = 0; j < SW; j++) begin
			if (sum_s2[j]) begin
				bitlen = BLW'(j + 1);
			end
		end
		kraw = 7'((RAD_W - int'(bitlen)) >> 1);
		kval = (kraw > 7'(K_MAX)) ? K_W'(K_MAX) : kraw[K_W-1:0];
	end

	logic                vld_s3;
	logic [RAD_W-1:0]    rad_s3;
	logic [SP_W-1:0]     pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= RAD_W'(sum_s2) << (2 * kval);
			pay_s3 <= {c_s2[0], c_s2[1], c_s2[2], (sum_s2 == '0), kval};
		end
	end

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	logic [SP_W-1:0]   sq_pay;

	cvm_sqrt #(.PW(SP_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_rad   (rad_s3),
		.in_pay   (pay_s3),
		.out_valid(sq_vld),
		.out_root (sq_root),
		.out_pay  (sq_pay)
	);

	logic signed [W-1:0] c_sq [LANES];
	logic                zero_sq;
	logic [K_W-1:0]      k_sq;

	assign c_sq[0] = sq_pay[SP_W-1 -: W];
	assign c_sq[1] = sq_pay[SP_W-1-W -: W];
	assign c_sq[2] = sq_pay[SP_W-1-2*W -: W];
	assign zero_sq = sq_pay[K_W];
	assign k_sq    = sq_pay[K_W-1:0];

	// s4: |c| * r
	logic                vld_s4;
	logic [W+R_W-1:0]    prod_s4 [LANES];
	logic [ROOT_W-1:0]   len_s4;
	logic [K_W-1:0]      k_s4;
	logic [DP_W-1:0]     pay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_mr
		logic [W-1:0] m;
		assign m = c_sq[l][W-1] ? W'(-c_sq[l]) : W'(c_sq[l]);
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s4[l] <= (W + R_W)'(m) * (W + R_W)'(radius_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4 <= sq_root;
			k_s4   <= k_sq;
			pay_s4 <= sq_pay[SP_W-1:K_W];
		end
	end

	// s5: scaled numerator with rounding term
	logic                vld_s5;
	logic [RAD_W-1:0]    num_s5 [LANES];
	logic [ROOT_W-1:0]   len_s5;
	logic [DP_W-1:0]     pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_num
		always_ff @(posedge clk) begin
			if (en) begin
				num_s5[l] <= (RAD_W'(prod_s4[l]) << k_s4) + RAD_W'(len_s4 >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s5 <= len_s4;
			pay_s5 <= pay_s4;
		end
	end

	logic              dv_vld;
	logic [QUOT_W-1:0] dv_quot [LANES];
	logic [DP_W-1:0]   dv_pay;

	cvm_div #(.PW(DP_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.in_num   (num_s5),
		.in_den   (len_s5),
		.in_pay   (pay_s5),
		.out_valid(dv_vld),
		.out_quot (dv_quot),
		.out_pay  (dv_pay)
	);

	logic signed [W-1:0] c_dv [LANES];
	assign c_dv[0] = dv_pay[DP_W-1 -: W];
	assign c_dv[1] = dv_pay[DP_W-1-W -: W];
	assign c_dv[2] = dv_pay[DP_W-1-2*W -: W];

	// s6: (p - c) * m
	logic                 vld_s6;
	logic signed [DW+MF_W-1:0] blend_s6 [LANES];
	logic signed [W-1:0]  c_s6 [LANES];
	logic                 zero_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_bl
		logic signed [DW-1:0] p;
		logic signed [DW-1:0] d;
		assign p = c_dv[l][W-1] ? -DW'(signed'({1'b0, dv_quot[l]}))
		                        : DW'(signed'({1'b0, dv_quot[l]}));
		assign d = p - DW'(c_dv[l]);
		always_ff @(posedge clk) begin
			if (en) begin
				blend_s6[l] <= (DW + MF_W)'(d) * (DW + MF_W)'(morph_q);
				c_s6[l]     <= c_dv[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= dv_pay[0];
		end
	end

	// s7: round, add, saturate
	localparam logic signed [DW+MF_W:0] HI = (DW + MF_W + 1)'((64'sd1 <<< (W - 1)) - 1);
	localparam logic signed [DW+MF_W:0] LO = -HI - 1;

	logic signed [W-1:0] o_nx [LANES];
	logic [LANES-1:0]    clip_nx;

	for (genvar l = 0; l < LANES; l++) begin : g_sat
		logic signed [DW+MF_W-1:0] t;
		logic signed [DW+MF_W:0]   o;
		assign t = (blend_s6[l] + (DW + MF_W)'(128)) >>> 8;
		assign o = (DW + MF_W + 1)'(c_s6[l]) + (DW + MF_W + 1)'(t);
		always_comb begin
			clip_nx[l] = 1'b0;
			if (zero_s6) begin
				o_nx[l] = c_s6[l];
			end else if (o > HI) begin
				o_nx[l]    = HI[W-1:0];
				clip_nx[l] = 1'b1;
			end else if (o < LO) begin
				o_nx[l]    = LO[W-1:0];
				clip_nx[l] = 1'b1;
			end else begin
				o_nx[l] = o[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x     <= o_nx[0];
			out_y     <= o_nx[1];
			out_z     <= o_nx[2];
			at_origin <= zero_s6;
			clipped   <= |clip_nx;
		end
	end

endmodule
